/* rtl/core/first_fit_range_allocator_assert.svh */
// assertion macros for the first-fit range allocator
`ifndef FIRST_FIT_RANGE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define FFRA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define FFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ffra_pkg.sv */
// types, codes and constants shared by the range allocator files
package ffra_pkg;

	localparam int SLOTS_DEF = 32;

	localparam logic [63:0] SIZE_MASK = 64'hFFFF_FFFF_FFFF_FFF0;

	// action codes
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_ALLOC = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOFIT   = 2'd1;
	localparam logic [1:0] STAT_NOSPARE = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	// map entry types and slot kinds
	localparam logic [3:0] TYPE_RAM  = 4'd0;
	localparam logic [3:0] TYPE_FREE = 4'd1;
	localparam logic [3:0] KIND_FREE = 4'd0;
	localparam logic [3:0] KIND_USED = 4'd1;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] entry_base;
		logic [63:0] entry_word;
		logic [63:0] request_size;
	} item_t;

	typedef struct packed {
		logic [63:0] address;
		logic [1:0]  status;
	} result_t;

	typedef struct packed {
		logic [63:0] base;
		logic [63:0] size;
		logic [3:0]  kind;
	} slot_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SUM,
		S_DIF,
		S_WRI,
		S_DONE
	} state_t;

	// firmware type to slot kind
	function automatic logic [3:0] kind_of(input logic [3:0] map_type);
		logic [3:0] k;
		case (map_type)
			TYPE_FREE: k = KIND_FREE;
			TYPE_RAM:  k = KIND_USED;
			default:   k = map_type;
		endcase
		return k;
	endfunction

endpackage

/* rtl/core/ffra_if.sv */
// valid/ready channels for allocator items and results
interface ffra_item_if;
	logic           valid;
	logic           ready;
	ffra_pkg::item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface ffra_result_if;
	logic             valid;
	logic             ready;
	ffra_pkg::result_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

/* rtl/core/first_fit_range_allocator.sv */
// first-fit range allocator: slot table, scan sequencer and shared 64-bit adder
// clear, load and unknown items go straight from the transfer into the result register
// allocate: a scan of the slot table, then sum, difference, write-back and result when a
//   range fits, or the scan and then the result when it fails; one item at a time
// results wait in an output register; a new item is taken once that register can refill
// arst_n clears the state machine, occupied flags, load count and result valid
module first_fit_range_allocator #(
	parameter int SLOTS = ffra_pkg::SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ffra_item_if.sink    item,
	ffra_result_if.source result
);
	import ffra_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	state_t           state_q, state_d;
	slot_t            slot_mem_q [SLOTS];
	slot_t            rd_q;
	logic [IW-1:0]    rd_addr;
	logic             mem_we;
	logic [IW-1:0]    mem_wa;
	slot_t            mem_wd;

	logic [SLOTS-1:0] occ_q;
	logic [CW-1:0]    load_cnt_q;
	logic [CW-1:0]    cnt_q;
	logic             found_q, spare_found_q;
	logic [IW-1:0]    fit_q, spare_q;
	logic [63:0]      req_q, base_q, size_q, sum_q;
	logic [1:0]       stat_q, stat_d;
	logic             stat_we;

	logic             res_valid_q;
	result_t          res_q, res_d;
	logic             res_load;
	logic             out_free, accept;

	logic [63:0]      alu_a, alu_b;
	logic             alu_sub;
	logic [64:0]      alu_sum;

	logic [IW-1:0]    idx_c;
	logic             eval, fit_now, spare_now, last, table_full;
	logic             do_clear, do_load;

	// shared add/subtract; carry out of a subtract means a >= b
	assign alu_sum = {1'b0, alu_a} + {1'b0, alu_sub ? ~alu_b : alu_b} + 65'(alu_sub);

	assign out_free   = !res_valid_q || result.ready;
	assign item.ready = (state_q == S_IDLE) && out_free;
	assign accept     = item.valid && item.ready;
	assign table_full = load_cnt_q == CW'(SLOTS);

	// read data in the scan belongs to the slot one behind the counter
	assign idx_c     = IW'(cnt_q - CW'(1));
	assign eval      = (state_q == S_SCAN) && (cnt_q != '0);
	assign fit_now   = eval && !found_q && occ_q[idx_c] && (rd_q.kind == KIND_FREE) && alu_sum[64];
	assign spare_now = eval && !spare_found_q && !occ_q[idx_c];
	assign last      = cnt_q == CW'(SLOTS);
	assign rd_addr   = cnt_q[IW-1:0];

	always_comb begin
		state_d  = state_q;
		alu_a    = rd_q.size;
		alu_b    = req_q;
		alu_sub  = 1'b1;
		mem_we   = 1'b0;
		mem_wa   = load_cnt_q[IW-1:0];
		mem_wd   = '{base: item.payload.entry_base,
			size: item.payload.entry_word & SIZE_MASK,
			kind: kind_of(item.payload.entry_word[3:0])};
		res_load = 1'b0;
		res_d    = '{address: '0, status: STAT_OK};
		stat_d   = STAT_OK;
		stat_we  = 1'b0;
		do_clear = 1'b0;
		do_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (item.payload.action)
						ACT_CLEAR: begin
							do_clear = 1'b1;
							res_load = 1'b1;
						end
						ACT_LOAD: begin
							res_load = 1'b1;
							if (table_full) begin
								res_d.status = STAT_FULL;
							end else begin
								do_load = 1'b1;
								mem_we  = 1'b1;
							end
						end
						ACT_ALLOC: begin
							state_d = S_SCAN;
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (last) begin
					stat_we = 1'b1;
					if (!(found_q || fit_now)) begin
						stat_d  = STAT_NOFIT;
						state_d = S_DONE;
					end else if (!(spare_found_q || spare_now)) begin
						stat_d  = STAT_NOSPARE;
						state_d = S_DONE;
					end else begin
						stat_d  = STAT_OK;
						state_d = S_SUM;
					end
				end
			end
			S_SUM: begin
				alu_a   = base_q;
				alu_sub = 1'b0;
				state_d = S_DIF;
			end
			S_DIF: begin
				// remainder goes to the spare slot, even when it is empty
				alu_a   = size_q;
				mem_we  = 1'b1;
				mem_wa  = spare_q;
				mem_wd  = '{base: sum_q, size: alu_sum[63:0], kind: KIND_FREE};
				state_d = S_WRI;
			end
			S_WRI: begin
				mem_we  = 1'b1;
				mem_wa  = fit_q;
				mem_wd  = '{base: base_q, size: req_q, kind: KIND_USED};
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					res_load       = 1'b1;
					res_d.status   = stat_q;
					res_d.address  = (stat_q == STAT_OK) ? base_q : '0;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// slot table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem_q[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= slot_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q         <= '0;
			load_cnt_q    <= '0;
			cnt_q         <= '0;
			found_q       <= 1'b0;
			spare_found_q <= 1'b0;
			stat_q        <= STAT_OK;
			res_valid_q   <= 1'b0;
		end else begin
			if (do_clear) begin
				occ_q      <= '0;
				load_cnt_q <= '0;
			end
			if (do_load) begin
				occ_q[load_cnt_q[IW-1:0]] <= 1'b1;
				load_cnt_q                <= load_cnt_q + CW'(1);
			end
			if (state_q == S_DIF) begin
				occ_q[spare_q] <= 1'b1;
			end
			if (accept) begin
				cnt_q         <= '0;
				found_q       <= 1'b0;
				spare_found_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				cnt_q <= cnt_q + CW'(1);
				if (fit_now) begin
					found_q <= 1'b1;
				end
				if (spare_now) begin
					spare_found_q <= 1'b1;
				end
			end
			if (stat_we) begin
				stat_q <= stat_d;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= item.payload.request_size;
		end
		if (fit_now) begin
			fit_q  <= idx_c;
			base_q <= rd_q.base;
			size_q <= rd_q.size;
		end
		if (spare_now) begin
			spare_q <= idx_c;
		end
		if (state_q == S_SUM) begin
			sum_q <= alu_sum[63:0];
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

`include "first_fit_range_allocator_assert.svh"

	`FFRA_ASSERT_SAME(a_load_cnt_range, 1'b1, load_cnt_q <= CW'(SLOTS), "load count past capacity")
	`FFRA_ASSERT_NEXT(a_alloc_starts_scan, accept && (item.payload.action == ACT_ALLOC), (state_q == S_SCAN) && (cnt_q == '0), "allocate did not start a scan")
	`FFRA_ASSERT_SAME(a_spare_unoccupied, state_q == S_DIF, !occ_q[spare_q], "remainder slot already occupied")
	`FFRA_ASSERT_SAME(a_nospare_full, $rose(res_valid_q) && (res_q.status == STAT_NOSPARE), &occ_q, "no spare slot reported with a free slot")

endmodule
